// ----- src/calc_pkg.sv -----
`timescale 1ns / 1ps

package calc_pkg;

  localparam int unsigned FreqW   = 17;
  localparam int unsigned PeriodW = 10;
  localparam int unsigned CodeW   = 12;
  localparam int unsigned CurrW   = 11;
  localparam int unsigned HystW   = 8;
  localparam int unsigned CfgIdxW = 2;

  // restoring division of 2^16 by the period code, one quotient bit per step
  localparam int unsigned DivSteps = FreqW;
  localparam int unsigned CntW     = $clog2(DivSteps);
  localparam logic [FreqW-1:0] Dividend = 17'h10000;

  localparam logic [10:0] CurrScale = 11'd1800;

  localparam logic [1:0] OpSample = 2'd0;
  localparam logic [1:0] OpStart  = 2'd1;
  localparam logic [1:0] OpStop   = 2'd2;

  localparam logic [1:0] LvlNc  = 2'd0;
  localparam logic [1:0] LvlOne = 2'd1;
  localparam logic [1:0] LvlTwo = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgThreshold = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHystUp    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgHystDown  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgMinFreq   = 2'd3;

  localparam logic [FreqW-1:0] ThresholdRst = 17'd145;
  localparam logic [HystW-1:0] HystUpRst    = 8'd8;
  localparam logic [HystW-1:0] HystDownRst  = 8'd5;
  localparam logic [FreqW-1:0] MinFreqRst   = 17'd100;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] freq_high_byte;
    logic [7:0] freq_low_byte;
    logic [7:0] curr_high_byte;
    logic [7:0] curr_low_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]       alignment_level;
    logic             reading_valid;
    logic [FreqW-1:0] frequency;
    logic [CurrW-1:0] current_ma;
  } out_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic need_div;
  } sts_t;

endpackage

// ----- src/calc_ctrl.sv -----
`timescale 1ns / 1ps

module calc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  calc_pkg::sts_t  sts_i,
  output calc_pkg::cmd_t  cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StFin  = 2'd2;

  localparam logic [calc_pkg::CntW-1:0] LastStep =
    calc_pkg::CntW'(calc_pkg::DivSteps - 1);

  logic [1:0]                state_q, state_d;
  logic [calc_pkg::CntW-1:0] cnt_q, cnt_d;
  logic                      out_valid_q, out_valid_d;
  logic                      out_free;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  assign cmd_o.load   = in_valid_i && in_ready_o;
  assign cmd_o.step   = (state_q == StDiv);
  assign cmd_o.finish = (state_q == StFin) && out_free;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      StIdle: begin
        cnt_d = '0;
        if (cmd_o.load) begin
          state_d = sts_i.need_div ? StDiv : StFin;
        end
      end
      StDiv: begin
        if (cnt_q == LastStep) begin
          state_d = StFin;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StFin: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- src/calc_dp.sv -----
`timescale 1ns / 1ps

module calc_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  calc_pkg::in_t                    in_data_i,
  input  logic                             cfg_we_i,
  input  logic [calc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [calc_pkg::FreqW-1:0]       cfg_wdata_i,
  input  calc_pkg::cmd_t                   cmd_i,
  output calc_pkg::sts_t                   sts_o,
  output calc_pkg::out_t                   out_data_o
);

  localparam int unsigned FW = calc_pkg::FreqW;

  // configuration
  logic [FW-1:0]                 thr_q, min_q;
  logic [calc_pkg::HystW-1:0]    up_q, dn_q;

  // architectural state
  logic [1:0]    level_q, level_d;
  logic [FW-1:0] rep_freq_q, rep_freq_d;

  // per-item working registers
  logic [1:0]                   op_q;
  logic [calc_pkg::PeriodW-1:0] period_q;
  logic [calc_pkg::CurrW-1:0]   scaled_q;
  logic [calc_pkg::PeriodW:0]   rem_q;
  logic [FW-1:0]                dvd_q;
  logic [FW-1:0]                quo_q;
  calc_pkg::out_t               out_q, out_d;

  logic [calc_pkg::PeriodW-1:0] in_period;
  logic [calc_pkg::CodeW-1:0]   in_code;
  logic [22:0]                  prod;
  logic [calc_pkg::PeriodW:0]   trial;
  logic                         qbit;
  logic [calc_pkg::PeriodW:0]   rem_next;

  assign in_period = {in_data_i.freq_high_byte, in_data_i.freq_low_byte[7:6]};
  assign in_code   = {in_data_i.curr_high_byte, in_data_i.curr_low_byte[7:4]};
  assign prod      = 23'(in_code) * 23'(calc_pkg::CurrScale);

  assign sts_o.need_div = ((in_data_i.opcode == calc_pkg::OpSample) ||
                           (in_data_i.opcode == calc_pkg::OpStart)) &&
                          (in_period != '0);

  // restoring divider step
  assign trial    = {rem_q[calc_pkg::PeriodW-1:0], dvd_q[FW-1]};
  assign qbit     = (trial >= {1'b0, period_q});
  assign rem_next = qbit ? (trial - {1'b0, period_q}) : trial;

  function automatic logic [1:0] next_level(
    input logic [1:0]                  lvl,
    input logic [FW-1:0]               f,
    input logic [FW-1:0]               thr,
    input logic [FW-1:0]               fmin,
    input logic [calc_pkg::HystW-1:0]  up,
    input logic [calc_pkg::HystW-1:0]  dn
  );
    logic [FW:0] f_x, thr_x, min_x, thr_up, f_dn;
    logic [1:0]  res;
    f_x    = {1'b0, f};
    thr_x  = {1'b0, thr};
    min_x  = {1'b0, fmin};
    thr_up = thr_x + (FW+1)'(up);
    // f <= thr - dn, kept unsigned by moving dn to the left side
    f_dn   = f_x + (FW+1)'(dn);
    res    = lvl;
    unique case (lvl)
      calc_pkg::LvlNc: begin
        if (f_x >= thr_x)      res = calc_pkg::LvlTwo;
        else if (f_x > min_x)  res = calc_pkg::LvlOne;
        else                   res = calc_pkg::LvlNc;
      end
      calc_pkg::LvlOne: begin
        if (f_x > thr_up)      res = calc_pkg::LvlTwo;
        else if (f_x < min_x)  res = calc_pkg::LvlNc;
        else                   res = calc_pkg::LvlOne;
      end
      calc_pkg::LvlTwo: begin
        if (f_x < min_x)       res = calc_pkg::LvlNc;
        else if (f_dn <= thr_x) res = calc_pkg::LvlOne;
        else                   res = calc_pkg::LvlTwo;
      end
      default: res = lvl;
    endcase
    return res;
  endfunction

  always_comb begin
    logic [1:0] base;
    base       = (op_q == calc_pkg::OpStart) ? calc_pkg::LvlNc : level_q;
    level_d    = level_q;
    rep_freq_d = rep_freq_q;
    out_d.reading_valid = 1'b0;
    out_d.current_ma    = '0;
    unique case (op_q)
      calc_pkg::OpSample, calc_pkg::OpStart: begin
        level_d = base;
        if (period_q == '0) begin
          rep_freq_d = '0;
        end else begin
          rep_freq_d = quo_q;
          if (scaled_q != '0) begin
            level_d             = next_level(base, quo_q, thr_q, min_q, up_q, dn_q);
            out_d.reading_valid = 1'b1;
            out_d.current_ma    = scaled_q;
          end
        end
      end
      calc_pkg::OpStop: level_d = calc_pkg::LvlNc;
      default: ;
    endcase
    out_d.alignment_level = level_d;
    out_d.frequency       = rep_freq_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= calc_pkg::ThresholdRst;
      up_q       <= calc_pkg::HystUpRst;
      dn_q       <= calc_pkg::HystDownRst;
      min_q      <= calc_pkg::MinFreqRst;
      level_q    <= calc_pkg::LvlNc;
      rep_freq_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          calc_pkg::CfgThreshold: thr_q <= cfg_wdata_i;
          calc_pkg::CfgHystUp:    up_q  <= cfg_wdata_i[calc_pkg::HystW-1:0];
          calc_pkg::CfgHystDown:  dn_q  <= cfg_wdata_i[calc_pkg::HystW-1:0];
          calc_pkg::CfgMinFreq:   min_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.finish) begin
        level_q    <= level_d;
        rep_freq_q <= rep_freq_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= in_data_i.opcode;
      period_q <= in_period;
      scaled_q <= prod[22:12];
      rem_q    <= '0;
      dvd_q    <= calc_pkg::Dividend;
      quo_q    <= '0;
    end else if (cmd_i.step) begin
      rem_q <= rem_next;
      dvd_q <= {dvd_q[FW-2:0], 1'b0};
      quo_q <= {quo_q[FW-2:0], qbit};
    end
    if (cmd_i.finish) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

// ----- src/coil_alignment_level_classifier.sv -----
`timescale 1ns / 1ps
// A sample or start with a nonzero period code runs 17 divider steps and then
// the finish state before its result is valid; other items go straight to finish.
// A new item is accepted only when idle, after the previous one has finished.
// A finished result waits in the output register while the next item runs.
// Reset (rst_ni low, async) clears level, reported frequency and handshakes,
// and restores the configuration registers to their defaults.

module coil_alignment_level_classifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  calc_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output calc_pkg::out_t                out_data_o,
  input  logic                          cfg_we_i,
  input  logic [calc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [calc_pkg::FreqW-1:0]    cfg_wdata_i
);

  calc_pkg::cmd_t cmd;
  calc_pkg::sts_t sts;

  calc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  calc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule
